// ===== hdl/sorted_priority_queue_assert.svh =====
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// cause in one cycle, effect in the next
`define SPQ_ASSERT_NEXT(label, clk_sig, rst_n_sig, cause, effect, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(cause) |=> (effect)) else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(label, clk_sig, rst_n_sig, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk_sig, rst_n_sig, cause, effect, msg)

`endif

`endif

// ===== hdl/spq_pkg.sv =====
// types, widths and codes shared by the sorted priority queue files
package spq_pkg;

	localparam int DATA_WIDTH    = 32;
	localparam int PRIO_WIDTH    = 8;
	localparam int DEPTH_DEFAULT = 8;
	localparam int COUNT_OUT_W   = 4;
	localparam int STATUS_W      = 2;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                  opcode;
		logic [DATA_WIDTH-1:0] item_data;
		logic [PRIO_WIDTH-1:0] item_priority;
	} spq_item_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0]  out_data;
		logic                   out_valid;
		logic [STATUS_W-1:0]    status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} spq_result_t;

	// operation broadcast to every cell of the chain
	typedef struct packed {
		logic                  enq;
		logic                  deq;
		logic [DATA_WIDTH-1:0] data;
		logic [PRIO_WIDTH-1:0] prio;
	} spq_op_t;

endpackage

// ===== hdl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
module spq_cell
	import spq_pkg::*;
(
	input  logic                  clk,
	input  spq_op_t               op,
	input  logic                  occupied,
	input  logic                  tail,
	input  logic                  left_gt,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [PRIO_WIDTH-1:0] left_prio,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [PRIO_WIDTH-1:0] right_prio,
	output logic                  gt,
	output logic [DATA_WIDTH-1:0] data,
	output logic [PRIO_WIDTH-1:0] prio
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	// stored entry sorts strictly after the new one
	assign gt = occupied && (prio_q > op.prio);

	always_ff @(posedge clk) begin
		if (op.enq && (gt || tail)) begin
			if (left_gt) begin
				data_q <= left_data;
				prio_q <= left_prio;
			end else begin
				data_q <= op.data;
				prio_q <= op.prio;
			end
		end else if (op.deq && occupied) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

	assign data = data_q;
	assign prio = prio_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// sorted priority queue: top level with the cell chain and result register
//
// usage
//   - raise start with an item; it transfers at the clock edge where start is
//     high and busy is low. busy is held low: an item may transfer every cycle
//   - opcode OP_ENQ inserts item_data behind every entry whose priority number
//     is less than or equal to item_priority, so ties leave in arrival order
//   - opcode OP_DEQ removes the front entry (lowest priority number)
//   - each item gives one result, shown for one cycle with done high, in the
//     cycle right after the item transfers; one item a cycle
//   - the chain of cells takes the insert or the shift at the transfer edge:
//     every cell compares its own priority with the new one in parallel
//   - a full queue rejects an enqueue with ST_FULL, an empty queue answers a
//     dequeue with data 0 and ST_EMPTY; the entries stay as they were
//   - entry_count is the number held after the operation (low four bits)
//   - reset empties the queue and clears done; slot contents are not cleared
//   - the receiver cannot stall: a result not taken in its cycle is gone
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  spq_item_t   item,
	output logic        done,
	output spq_result_t result
);

	`include "sorted_priority_queue_assert.svh"

	localparam int CW = $clog2(DEPTH + 1);

	// fill count of the chain
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          full;
	logic          empty;
	logic          enq_en;
	logic          deq_en;
	spq_op_t       op;

	// result register
	logic        done_q;
	spq_result_t result_q;

	// chain wiring
	logic                  gt_w   [DEPTH];
	logic [DATA_WIDTH-1:0] data_w [DEPTH];
	logic [PRIO_WIDTH-1:0] prio_w [DEPTH];

	assign busy  = 1'b0;
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// rejected operations leave the chain untouched
	assign enq_en = start && (item.opcode == OP_ENQ) && !full;
	assign deq_en = start && (item.opcode == OP_DEQ) && !empty;

	assign op.enq  = enq_en;
	assign op.deq  = deq_en;
	assign op.data = item.item_data;
	assign op.prio = item.item_priority;

	always_comb begin
		count_nxt = count_q;
		if (enq_en) begin
			count_nxt = count_q + 1'b1;
		end else if (deq_en) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// cell i is occupied below the count, and the tail cell is the first free one;
	// the front cell has no left neighbor, the back cell refills from itself
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  left_gt;
		logic [DATA_WIDTH-1:0] left_data;
		logic [PRIO_WIDTH-1:0] left_prio;
		logic [DATA_WIDTH-1:0] right_data;
		logic [PRIO_WIDTH-1:0] right_prio;

		if (i == 0) begin : g_front
			assign left_gt   = 1'b0;
			assign left_data = item.item_data;
			assign left_prio = item.item_priority;
		end else begin : g_mid
			assign left_gt   = gt_w[i-1];
			assign left_data = data_w[i-1];
			assign left_prio = prio_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign right_data = data_w[i];
			assign right_prio = prio_w[i];
		end else begin : g_inner
			assign right_data = data_w[i+1];
			assign right_prio = prio_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (CW'(i) < count_q),
			.tail       (CW'(i) == count_q),
			.left_gt    (left_gt),
			.left_data  (left_data),
			.left_prio  (left_prio),
			.right_data (right_data),
			.right_prio (right_prio),
			.gt         (gt_w[i]),
			.data       (data_w[i]),
			.prio       (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= start;
		end
	end

	// result payload, captured for every transfer
	always_ff @(posedge clk) begin
		if (start) begin
			result_q.out_data    <= deq_en ? data_w[0] : '0;
			result_q.out_valid   <= deq_en;
			result_q.entry_count <= COUNT_OUT_W'(count_nxt);
			if (item.opcode == OP_ENQ) begin
				result_q.status <= full ? ST_FULL : ST_OK;
			end else begin
				result_q.status <= empty ? ST_EMPTY : ST_OK;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	`SPQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH),
		"fill count above depth")
	`SPQ_ASSERT_NEXT(a_done_follows_start, clk, arst_n, !start, !done,
		"result strobe without a transfer")
	`SPQ_ASSERT_NEXT(a_empty_dequeue, clk, arst_n,
		start && (item.opcode == OP_DEQ) && empty,
		done && (result.status == ST_EMPTY) && !result.out_valid,
		"dequeue on empty queue not reported")
	`SPQ_ASSERT_NEXT(a_full_enqueue, clk, arst_n,
		start && (item.opcode == OP_ENQ) && full,
		(result.status == ST_FULL) && $stable(count_q),
		"enqueue on full queue changed the queue")

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
// self-checking testbench for the sorted priority queue: directed and random transfers
`timescale 1ns / 100ps

module tb_sorted_priority_queue
	import spq_pkg::*;
();

	localparam int QDEPTH      = DEPTH_DEFAULT;
	localparam int RANDOM_EACH = 475;      // random items per idling phase
	localparam int DRAIN_LIMIT = 200;      // cycles allowed for the last results

	// tracks the sorted contents and holds the results still owed by the block
	class queue_scoreboard;
		logic [DATA_WIDTH-1:0] data_slot [QDEPTH];
		logic [PRIO_WIDTH-1:0] prio_slot [QDEPTH];
		int unsigned           held;
		spq_result_t           awaited [$];
		int unsigned           mismatches;

		function new();
			held       = 0;
			mismatches = 0;
		endfunction

		// work out the result of one accepted item and update the shadow list
		function void note_item(spq_item_t it);
			spq_result_t r;
			int          pos;
			r        = '0;
			r.status = ST_OK;
			if (it.opcode == OP_ENQ) begin
				if (held >= QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					// entries with a larger priority number move back one slot
					pos = held;
					while (pos > 0 && prio_slot[pos-1] > it.item_priority) begin
						data_slot[pos] = data_slot[pos-1];
						prio_slot[pos] = prio_slot[pos-1];
						pos--;
					end
					data_slot[pos] = it.item_data;
					prio_slot[pos] = it.item_priority;
					held++;
				end
			end else if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_data  = data_slot[0];
				r.out_valid = 1'b1;
				for (int k = 0; k + 1 < held; k++) begin
					data_slot[k] = data_slot[k+1];
					prio_slot[k] = prio_slot[k+1];
				end
				held--;
			end
			r.entry_count = held[COUNT_OUT_W-1:0];
			awaited.push_back(r);
		endfunction

		// compare one result against the oldest expectation
		function void check_result(spq_result_t got);
			spq_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing expected: %p", got);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (got.out_data !== want.out_data) begin
					$error("out_data: expected %h, got %h", want.out_data, got.out_data);
					mismatches++;
				end
				if (got.out_valid !== want.out_valid) begin
					$error("out_valid: expected %b, got %b", want.out_valid, got.out_valid);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, got.entry_count);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	spq_item_t   item;
	logic        done;
	spq_result_t result;

	queue_scoreboard sb = new();

	// percent of cycles in which the sender holds start low
	int unsigned idle_pct;

	sorted_priority_queue #(
		.DEPTH(QDEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous watchdog, far beyond the slowest correct run
	initial begin
		#2ms;
		$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

	// monitor: values are sampled at the edge before the driver's updates land,
	// so the item that transfers here and the result shown in the ending cycle
	// are both seen as they were during that cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(item);
			if (done)
				sb.check_result(result);
		end
	end

	// one transfer: random idle cycles first, then hold start until busy is low
	task automatic send_item(input logic op, input logic [DATA_WIDTH-1:0] dat,
			input logic [PRIO_WIDTH-1:0] prio);
		spq_item_t junk;
		while ($urandom_range(99) < idle_pct) begin
			// garbage on the item bus while start is low must be ignored
			junk.opcode        = 1'($urandom_range(1));
			junk.item_data     = DATA_WIDTH'($urandom);
			junk.item_priority = PRIO_WIDTH'($urandom_range(255));
			start <= 1'b0;
			item  <= junk;
			@(posedge clk);
		end
		start              <= 1'b1;
		item.opcode        <= op;
		item.item_data     <= dat;
		item.item_priority <= prio;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random data with the all-zero and all-one words now and then
	function automatic logic [DATA_WIDTH-1:0] pick_data();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// priorities from a few shapes: heavy ties, full range, extremes, top band
	function automatic logic [PRIO_WIDTH-1:0] pick_prio(input int unsigned shape);
		case (shape)
			0:       return PRIO_WIDTH'($urandom_range(3));
			1:       return PRIO_WIDTH'($urandom_range(255));
			2:       return $urandom_range(1) ? 8'hff : 8'h00;
			default: return PRIO_WIDTH'($urandom_range(255, 250));
		endcase
	endfunction

	initial begin
		int unsigned phase_idle [4];
		int unsigned sent;
		int unsigned burst;
		int unsigned enq_pct;
		int unsigned shape;
		int unsigned guard;

		// sender idling per phase; receiver stalls do not exist on this block
		phase_idle = '{0, 70, 0, 20};

		arst_n   <= 1'b0;
		start    <= 1'b0;
		item     <= '0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: dequeue when empty
		send_item(OP_DEQ, 32'h1234_5678, 8'h00);
		// fill with extremes and ties; equal priorities must leave in arrival order
		send_item(OP_ENQ, 32'hffff_ffff, 8'hff);
		send_item(OP_ENQ, 32'h0000_0000, 8'h00);
		send_item(OP_ENQ, 32'ha5a5_a5a5, 8'h80);
		send_item(OP_ENQ, 32'h0000_0001, 8'h00);
		send_item(OP_ENQ, 32'h8000_0000, 8'hff);
		send_item(OP_ENQ, 32'h5a5a_5a5a, 8'h07);
		send_item(OP_ENQ, 32'hdead_beef, 8'h80);
		send_item(OP_ENQ, 32'h0000_0002, 8'h00);
		// enqueue when full is rejected, whether it would go near the front or last
		send_item(OP_ENQ, 32'hcafe_f00d, 8'h00);
		send_item(OP_ENQ, 32'h7fff_ffff, 8'hff);
		// drain completely, then one more dequeue on empty
		repeat (QDEPTH) send_item(OP_DEQ, 32'hffff_ffff, 8'hff);
		send_item(OP_DEQ, 32'h0000_0000, 8'h00);
		// one entry in, then a tie right behind the front, then both out again
		send_item(OP_ENQ, 32'h0f0f_0f0f, 8'h10);
		send_item(OP_ENQ, 32'hf0f0_f0f0, 8'h10);
		send_item(OP_DEQ, 32'h0, 8'h0);
		send_item(OP_DEQ, 32'h0, 8'h0);

		// random: bursts lean toward filling or draining so every fill level,
		// including full and empty, is visited often
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			sent     = 0;
			while (sent < RANDOM_EACH) begin
				burst = $urandom_range(40, 4);
				case ($urandom_range(2))
					0:       enq_pct = 15;
					1:       enq_pct = 50;
					default: enq_pct = 85;
				endcase
				shape = $urandom_range(3);
				for (int b = 0; b < burst && sent < RANDOM_EACH; b++) begin
					if ($urandom_range(99) < enq_pct)
						send_item(OP_ENQ, pick_data(), pick_prio(shape));
					else
						send_item(OP_DEQ, DATA_WIDTH'($urandom),
							PRIO_WIDTH'($urandom_range(255)));
					sent++;
				end
			end
		end

		// stimulus done: this step carries the last update of start
		start <= 1'b0;
		guard = 0;
		while (sb.awaited.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		// the wait below catches any stray result
		repeat (4) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			$error("%0d results never arrived", sb.awaited.size());
			sb.mismatches++;
		end

		if (sb.mismatches == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

endmodule
